[sv/assert_macros.svh]
// Assertion macros used by the checker file of the waveform generator.
// Needs nothing else; take it in with `include before the first assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define PWTG_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define PWTG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/pwtg_pkg.sv]
// Shared types, codes and constant tables of the periodic waveform generator.
// No dependencies; every other RTL file refers to it by scoped names.
`default_nettype none
package pwtg_pkg;

  localparam int unsigned PointBits = 8;   // 256 points per period
  localparam int unsigned CodeBits  = 12;  // DAC code width

  localparam logic [2:0] KIND_SINE     = 3'd0;
  localparam logic [2:0] KIND_SQUARE   = 3'd1;
  localparam logic [2:0] KIND_TRIANGLE = 3'd2;
  localparam logic [2:0] KIND_EKG      = 3'd3;
  localparam logic [2:0] KIND_DC       = 3'd4;

  localparam logic [1:0] REG_WAVE_KIND = 2'd0;
  localparam logic [1:0] REG_LOW_CODE  = 2'd1;
  localparam logic [1:0] REG_HIGH_CODE = 2'd2;

  localparam logic [1:0] CALC_DIRECT   = 2'd0;
  localparam logic [1:0] CALC_SINE     = 2'd1;
  localparam logic [1:0] CALC_TRI_UP   = 2'd2;
  localparam logic [1:0] CALC_TRI_DOWN = 2'd3;

  typedef struct packed {
    logic [2:0]          wave_kind;
    logic [CodeBits-1:0] low_code;
    logic [CodeBits-1:0] high_code;
  } cfg_t;

  // Point of the period with the offset sine value (Q1.15 plus one) for it.
  typedef struct packed {
    logic [PointBits-1:0] point;
    logic [16:0]          sine_u;
  } phase_item_t;

  // 32768 * sin(k * pi / 128), k = 0..64
  localparam logic [15:0] QUARTER_SINE [65] = '{
    16'd0,     16'd804,   16'd1608,  16'd2411,  16'd3212,  16'd4011,  16'd4808,  16'd5602,
    16'd6393,  16'd7180,  16'd7962,  16'd8740,  16'd9512,  16'd10279, 16'd11039, 16'd11793,
    16'd12540, 16'd13279, 16'd14010, 16'd14733, 16'd15447, 16'd16151, 16'd16846, 16'd17531,
    16'd18205, 16'd18868, 16'd19520, 16'd20160, 16'd20788, 16'd21403, 16'd22006, 16'd22595,
    16'd23170, 16'd23732, 16'd24279, 16'd24812, 16'd25330, 16'd25833, 16'd26320, 16'd26791,
    16'd27246, 16'd27684, 16'd28106, 16'd28511, 16'd28899, 16'd29269, 16'd29622, 16'd29957,
    16'd30274, 16'd30572, 16'd30853, 16'd31114, 16'd31357, 16'd31581, 16'd31786, 16'd31972,
    16'd32138, 16'd32286, 16'd32413, 16'd32522, 16'd32610, 16'd32679, 16'd32729, 16'd32758,
    16'd32768
  };

  localparam logic [11:0] EKG_POINTS [256] = '{
    12'd1690, 12'd1680, 12'd1680, 12'd1669, 12'd1648, 12'd1648, 12'd1648, 12'd1680,
    12'd1680, 12'd1690, 12'd1680, 12'd1680, 12'd1680, 12'd1680, 12'd1680, 12'd1658,
    12'd1690, 12'd1690, 12'd1712, 12'd1690, 12'd1690, 12'd1680, 12'd1669, 12'd1669,
    12'd1680, 12'd1690, 12'd1690, 12'd1680, 12'd1669, 12'd1669, 12'd1669, 12'd1680,
    12'd1680, 12'd1680, 12'd1669, 12'd1669, 12'd1680, 12'd1690, 12'd1690, 12'd1680,
    12'd1690, 12'd1690, 12'd1680, 12'd1690, 12'd1690, 12'd1712, 12'd1680, 12'd1680,
    12'd1658, 12'd1648, 12'd1648, 12'd1648, 12'd1669, 12'd1669, 12'd1680, 12'd1690,
    12'd1690, 12'd1701, 12'd1680, 12'd1680, 12'd1669, 12'd1680, 12'd1680, 12'd1680,
    12'd1701, 12'd1701, 12'd1701, 12'd1690, 12'd1690, 12'd1701, 12'd1712, 12'd1712,
    12'd1722, 12'd1712, 12'd1712, 12'd1690, 12'd1669, 12'd1669, 12'd1680, 12'd1690,
    12'd1690, 12'd1690, 12'd1733, 12'd1733, 12'd1765, 12'd1776, 12'd1861, 12'd1882,
    12'd1936, 12'd1936, 12'd1968, 12'd1989, 12'd1989, 12'd2032, 12'd2053, 12'd2053,
    12'd2085, 12'd2149, 12'd2069, 12'd2080, 12'd2058, 12'd2058, 12'd1930, 12'd1930,
    12'd1845, 12'd1824, 12'd1792, 12'd1872, 12'd1840, 12'd1754, 12'd1754, 12'd1722,
    12'd1680, 12'd1680, 12'd1680, 12'd1637, 12'd1637, 12'd1637, 12'd1637, 12'd1637,
    12'd1626, 12'd1648, 12'd1648, 12'd1637, 12'd1605, 12'd1605, 12'd1616, 12'd1680,
    12'd1680, 12'd1765, 12'd1776, 12'd1861, 12'd2042, 12'd2106, 12'd2021, 12'd1776,
    12'd2480, 12'd2400, 12'd2176, 12'd1632, 12'd1637, 12'd1360, 12'd933,  12'd928,
    12'd1962, 12'd1962, 12'd2042, 12'd2149, 12'd3141, 12'd3141, 12'd2320, 12'd1200,
    12'd1200, 12'd1392, 12'd1669, 12'd1669, 12'd1658, 12'd1701, 12'd1701, 12'd1701,
    12'd1701, 12'd1701, 12'd1722, 12'd1690, 12'd1690, 12'd1690, 12'd1680, 12'd1680,
    12'd1690, 12'd1690, 12'd1690, 12'd1669, 12'd1669, 12'd1669, 12'd1701, 12'd1733,
    12'd1733, 12'd1754, 12'd1744, 12'd1744, 12'd1733, 12'd1733, 12'd1733, 12'd1722,
    12'd1765, 12'd1765, 12'd1765, 12'd1733, 12'd1733, 12'd1733, 12'd1722, 12'd1722,
    12'd1701, 12'd1690, 12'd1690, 12'd1701, 12'd1690, 12'd1690, 12'd1701, 12'd1701,
    12'd1701, 12'd1701, 12'd1722, 12'd1722, 12'd1712, 12'd1722, 12'd1722, 12'd1733,
    12'd1733, 12'd1733, 12'd1733, 12'd1712, 12'd1712, 12'd1712, 12'd1733, 12'd1733,
    12'd1733, 12'd1733, 12'd1733, 12'd1733, 12'd1744, 12'd1744, 12'd1744, 12'd1744,
    12'd1744, 12'd1744, 12'd1733, 12'd1733, 12'd1722, 12'd1722, 12'd1722, 12'd1722,
    12'd1722, 12'd1722, 12'd1733, 12'd1722, 12'd1722, 12'd1722, 12'd1722, 12'd1722,
    12'd1701, 12'd1669, 12'd1669, 12'd1680, 12'd1690, 12'd1690, 12'd1690, 12'd1701,
    12'd1701, 12'd1712, 12'd1712, 12'd1712, 12'd1690, 12'd1669, 12'd1669, 12'd1680
  };

  // Sine of the point plus one, in units of 2^-15: 0..65536.
  function automatic logic [16:0] sine_offset(input logic [PointBits-1:0] point);
    logic [5:0]  r;
    logic [6:0]  mirror;
    logic [15:0] s;
    begin
      r      = point[5:0];
      mirror = 7'd64 - {1'b0, r};
      s      = point[6] ? QUARTER_SINE[mirror] : QUARTER_SINE[r];
      sine_offset = point[7] ? (17'd32768 - {1'b0, s}) : (17'd32768 + {1'b0, s});
    end
  endfunction

endpackage
`default_nettype wire

[sv/periodic_waveform_table_generator.sv]
// Periodic waveform generator: each accepted request on the input stream is
// one sample tick and yields one DAC code on the output stream, for sine,
// square, triangle, EKG table or DC shapes over a 256-point period. A new
// request is taken every clock cycle unless the output stalls. A result
// passes the input register, the register after the single 13 x 18
// multiplier and the output register. A stage holds while the next one is
// full and held, so a stalled output backs up at most three items.
// tlast marks the last point of the period. Configuration writes belong to
// idle periods. Depends on pwtg_pkg, pwtg_cfg, pwtg_phase and pwtg_calc.
`default_nettype none
module periodic_waveform_table_generator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [11:0] cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [11:0] sample, [19:12] point_index, [23:20] zero
  output logic             m_tlast    // period_end
);

  pwtg_pkg::cfg_t                 cfg;
  pwtg_pkg::phase_item_t          item;
  logic                           item_valid;
  logic                           item_ready;
  logic [pwtg_pkg::CodeBits-1:0]  sample;
  logic [pwtg_pkg::PointBits-1:0] point;

  pwtg_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pwtg_phase u_phase (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .restart    (s_tdata[0]),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  pwtg_calc u_calc (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_sample (sample),
    .out_point  (point)
  );

  assign m_tdata = {4'd0, point, sample};
  assign m_tlast = (point == '1);

endmodule
`default_nettype wire

[sv/pwtg_cfg.sv]
// Configuration registers of the waveform generator: kind and the two levels.
// Depends on pwtg_pkg for the register indexes and the cfg_t bundle.
`default_nettype none
module pwtg_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [1:0]                     cfg_index,
  input  wire logic [pwtg_pkg::CodeBits-1:0]  cfg_data,
  output pwtg_pkg::cfg_t                      cfg
);

  pwtg_pkg::cfg_t cfg_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg.wave_kind <= pwtg_pkg::KIND_SINE;
      cfg_reg.low_code  <= '0;
      cfg_reg.high_code <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        pwtg_pkg::REG_WAVE_KIND: cfg_reg.wave_kind <= cfg_data[2:0];
        pwtg_pkg::REG_LOW_CODE:  cfg_reg.low_code  <= cfg_data;
        pwtg_pkg::REG_HIGH_CODE: cfg_reg.high_code <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_reg;

endmodule
`default_nettype wire

[sv/pwtg_phase.sv]
// Input stage: phase counter with restart, and the sine lookup for the point.
// Depends on pwtg_pkg for the quarter-wave table and phase_item_t.
`default_nettype none
module pwtg_phase (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          restart,
  output logic               item_valid,
  input  wire logic          item_ready,
  output pwtg_pkg::phase_item_t item
);

  logic [pwtg_pkg::PointBits-1:0] phase;
  logic [pwtg_pkg::PointBits-1:0] point_now;
  logic                           valid;
  pwtg_pkg::phase_item_t          item_reg;
  logic                           accept;

  assign in_ready  = !valid || item_ready;
  assign accept    = in_valid && in_ready;
  assign point_now = restart ? '0 : phase;

  // The counter is 8 bits wide, so it wraps to zero after the last point.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      valid <= 1'b0;
    end else begin
      if (in_ready) valid <= in_valid;
      if (accept) phase <= point_now + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_reg.point  <= point_now;
      item_reg.sine_u <= pwtg_pkg::sine_offset(point_now);
    end
  end

  assign item_valid = valid;
  assign item       = item_reg;

endmodule
`default_nettype wire

[sv/pwtg_calc.sv]
// Shape stages: one multiply for sine or triangle, then offset, rounding and
// saturation into the output register. Depends on pwtg_pkg.
`default_nettype none
module pwtg_calc (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire pwtg_pkg::cfg_t                   cfg,
  input  wire logic                             item_valid,
  output logic                                  item_ready,
  input  wire pwtg_pkg::phase_item_t            item,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [pwtg_pkg::CodeBits-1:0]         out_sample,
  output logic [pwtg_pkg::PointBits-1:0]        out_point
);

  logic                            v2;
  logic                            v3;
  logic                            en2;
  logic                            en3;
  logic signed [12:0]              diff;
  logic signed [17:0]              mul_a;
  logic [1:0]                      mode;
  logic [pwtg_pkg::CodeBits-1:0]   direct;
  logic signed [30:0]              prod;
  logic [1:0]                      mode2;
  logic [pwtg_pkg::CodeBits-1:0]   direct2;
  logic [pwtg_pkg::PointBits-1:0]  point2;
  logic signed [31:0]              prod_x;
  logic signed [31:0]              low_x;
  logic signed [31:0]              high_x;
  logic signed [31:0]              num;
  logic [pwtg_pkg::CodeBits-1:0]   sample_next;
  logic [pwtg_pkg::CodeBits-1:0]   sample;
  logic [pwtg_pkg::PointBits-1:0]  point3;

  assign en3        = !v3 || out_ready;
  assign en2        = !v2 || en3;
  assign item_ready = en2;

  assign diff = $signed({1'b0, cfg.high_code}) - $signed({1'b0, cfg.low_code});

  // Triangle step is d * 512 in 16-bit fraction, so the multiply is by the
  // distance into the current half, and the shift comes after.
  always_comb begin
    mode   = pwtg_pkg::CALC_DIRECT;
    direct = cfg.low_code;
    mul_a  = $signed({1'b0, item.sine_u});
    case (cfg.wave_kind)
      pwtg_pkg::KIND_SINE: mode = pwtg_pkg::CALC_SINE;
      pwtg_pkg::KIND_SQUARE: direct = item.point[7] ? cfg.high_code : cfg.low_code;
      pwtg_pkg::KIND_TRIANGLE: begin
        mul_a = $signed({11'd0, item.point[6:0]});
        if (item.point == '1) mode = pwtg_pkg::CALC_DIRECT;
        else if (item.point[7]) mode = pwtg_pkg::CALC_TRI_DOWN;
        else mode = pwtg_pkg::CALC_TRI_UP;
      end
      pwtg_pkg::KIND_EKG: direct = pwtg_pkg::EKG_POINTS[item.point];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en2) v2 <= item_valid;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && item_valid) begin
      prod    <= 31'(diff) * 31'(mul_a);
      mode2   <= mode;
      direct2 <= direct;
      point2  <= item.point;
    end
  end

  assign prod_x = {prod[30], prod};
  assign low_x  = $signed({4'd0, cfg.low_code, 16'd0});
  assign high_x = $signed({4'd0, cfg.high_code, 16'd0});

  always_comb begin
    case (mode2)
      pwtg_pkg::CALC_SINE:     num = low_x + prod_x + 32'sd32768;
      pwtg_pkg::CALC_TRI_UP:   num = low_x + (prod_x <<< 9);
      pwtg_pkg::CALC_TRI_DOWN: num = high_x - (prod_x <<< 9);
      default:                 num = '0;
    endcase
    if (mode2 == pwtg_pkg::CALC_DIRECT) sample_next = direct2;
    else if (num[31]) sample_next = '0;
    else if (|num[30:28]) sample_next = '1;
    else sample_next = num[27:16];
  end

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      sample <= sample_next;
      point3 <= point2;
    end
  end

  assign out_valid  = v3;
  assign out_sample = sample;
  assign out_point  = point3;

endmodule
`default_nettype wire

[sv/pwtg_checker.sv]
// Port-level checks of the waveform generator, bound to its top level.
// Depends on assert_macros.svh for the assertion macros.
`default_nettype none
`include "assert_macros.svh"
module pwtg_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata,
  input wire logic        m_tlast
);

  // A result waiting on the output holds its contents.
  `PWTG_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output changed while stalled")

  // The end-of-period mark goes exactly with the last point.
  `PWTG_ASSERT(a_last_point, clk, rst, m_tvalid |-> (m_tlast == (m_tdata[19:12] == 8'd255)), "tlast does not match point 255")

  // Reset empties the pipeline.
  `PWTG_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid, "output valid right after reset")

  // With the output free, the input is never held off.
  `PWTG_ASSERT(a_no_false_stall, clk, rst, !m_tvalid |-> s_tready, "input stalled with an empty output")

  // Padding bits stay zero.
  `PWTG_ASSERT(a_pad_zero, clk, rst, m_tvalid |-> (m_tdata[23:20] == 4'd0), "padding bits set")

endmodule

bind periodic_waveform_table_generator pwtg_checker u_pwtg_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
`default_nettype wire
